// File: rtl/assert_macros.svh
// assertion helpers used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is high
`define DDA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that is also checked during reset
`define DDA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/dda_pkg.sv
package dda_pkg;

  // number of axis cells in the chain
  localparam int AXES = 5;

  localparam int INCR_W = 32;
  localparam int TICK_W = 24;
  localparam int ACC_W  = 48;
  localparam int RF_W   = 8;

  // command codes
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_LINE  = 2'd1;
  localparam logic [1:0] CMD_DWELL = 2'd2;

  // configuration register indexes
  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_POLARITY     = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RESET_FACTOR = 8'd1;

  // what a token asks of each cell
  typedef enum logic [1:0] {
    TOK_NONE,
    TOK_LOAD,
    TOK_STEP
  } tok_kind_t;

  // token handed from cell to cell
  typedef struct packed {
    logic                                valid;
    tok_kind_t                           kind;
    logic                                restart;
    logic [ACC_W-1:0]                    tts;
    logic [AXES-1:0][INCR_W-1:0]         incr;
    logic [AXES-1:0]                     step_mask;
    logic [AXES-1:0]                     dir_mask;
    logic                                done;
    logic                                busy;
  } tok_t;

endpackage

// File: rtl/dda_ifs.sv
// command channel
interface dda_item_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          command;
  logic [dda_pkg::TICK_W-1:0]          tick_count;
  logic signed [dda_pkg::INCR_W-1:0]   incr_axis1;
  logic signed [dda_pkg::INCR_W-1:0]   incr_axis2;
  logic signed [dda_pkg::INCR_W-1:0]   incr_axis3;
  logic signed [dda_pkg::INCR_W-1:0]   incr_axis4;
  logic signed [dda_pkg::INCR_W-1:0]   incr_axis5;

  modport source (
    output valid, command, tick_count,
    output incr_axis1, incr_axis2, incr_axis3, incr_axis4, incr_axis5,
    input  ready
  );
  modport sink (
    input  valid, command, tick_count,
    input  incr_axis1, incr_axis2, incr_axis3, incr_axis4, incr_axis5,
    output ready
  );
endinterface

// step result channel
interface dda_result_if;
  logic       valid;
  logic       ready;
  logic [4:0] step_mask;
  logic [4:0] dir_mask;
  logic       segment_done;
  logic       busy_res;

  modport source (output valid, step_mask, dir_mask, segment_done, busy_res, input ready);
  modport sink (input valid, step_mask, dir_mask, segment_done, busy_res, output ready);
endinterface

// register write channel
interface dda_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [dda_pkg::CFG_IDX_W-1:0]  index;
  logic [7:0]                     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/multi_axis_dda_step_generator.sv
// Five-axis DDA step generator. Each command beat (tick, line load, dwell load) gives
// one result beat, in order. A beat enters a control stage that tracks the ticks left,
// the dwell flag and the accumulator restart, then walks down a row of five axis cells,
// one cell per cycle; each cell owns one axis's phase accumulator, increment and direction
// and fills in its step and direction bits. A result leaves once its beat is registered in
// the control stage and in each of the five cells, and one command is taken every cycle
// as long as results are taken, since every stage holds one beat and the whole row moves
// as one; each cell's 48-bit accumulate-and-compare is the longest path. A stalled result
// holds the whole row. Register writes may only be issued while no commands are in flight.
`include "assert_macros.svh"

module multi_axis_dda_step_generator #(
  parameter int SUBSTEPS = 65536
) (
  input  logic           clk,
  input  logic           rst,
  dda_item_if.sink       item,
  dda_result_if.source   result,
  dda_cfg_if.sink        cfg
);

  dda_pkg::tok_t            tok [dda_pkg::AXES+1];
  logic [dda_pkg::AXES-1:0] polarity;
  logic                     en;
  dda_pkg::tok_t            last;
  logic                     line_beat;
  logic                     head_load;
  logic                     step_seen;

  assign last = tok[dda_pkg::AXES];

  // whole row advances unless the result register is full and stalled
  assign en = !last.valid || result.ready;

  dda_front #(
    .SUBSTEPS (SUBSTEPS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .item     (item),
    .cfg      (cfg),
    .polarity (polarity),
    .tok      (tok[0])
  );

  // one cell per axis
  for (genvar g = 0; g < dda_pkg::AXES; g++) begin : g_cell
    dda_cell #(
      .IDX (g)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .pol     (polarity[g]),
      .tok_in  (tok[g]),
      .tok_out (tok[g+1])
    );
  end

  assign result.valid        = last.valid;
  assign result.step_mask    = last.step_mask;
  assign result.dir_mask     = last.dir_mask;
  assign result.segment_done = last.done;
  assign result.busy_res     = last.busy;

  // terms used by the checks
  assign line_beat = item.valid && item.ready && item.command == dda_pkg::CMD_LINE;
  assign head_load = tok[0].valid && tok[0].kind == dda_pkg::TOK_LOAD;
  assign step_seen = last.valid && last.step_mask != '0;

  // checks
  `DDA_ASSERT(a_done_idle, last.valid && last.done |-> !last.busy, "segment done while busy")
  `DDA_ASSERT(a_stall_holds, !en |=> $stable(last), "result token moved during a stall")
  `DDA_ASSERT(a_line_load, line_beat |=> head_load, "line command lost at the head")
  `DDA_ASSERT(a_step_kind, step_seen |-> last.kind == dda_pkg::TOK_STEP, "step without a tick")

endmodule

// File: rtl/dda_front.sv
module dda_front #(
  parameter int SUBSTEPS = 65536
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  dda_item_if.sink                   item,
  dda_cfg_if.sink                    cfg,
  output logic [dda_pkg::AXES-1:0]   polarity,
  output dda_pkg::tok_t              tok
);

  logic [dda_pkg::TICK_W-1:0] ticks_left, ticks_left_next;
  logic [dda_pkg::TICK_W-1:0] last_len;
  logic                       dwelling, dwelling_next;
  logic [dda_pkg::AXES-1:0]   polarity_mask;
  logic [dda_pkg::RF_W-1:0]   reset_factor;
  logic                       fire;
  dda_pkg::tok_t              tok_next;
  logic [dda_pkg::TICK_W+dda_pkg::RF_W-1:0] scaled_ticks;

  assign item.ready = en;
  assign cfg.ready  = 1'b1;
  assign fire       = item.valid && en;
  assign polarity   = polarity_mask;

  assign scaled_ticks = (dda_pkg::TICK_W+dda_pkg::RF_W)'(item.tick_count)
                      * (dda_pkg::TICK_W+dda_pkg::RF_W)'(reset_factor);

  // decode the command and build the token for the chain
  always_comb begin
    ticks_left_next = ticks_left;
    dwelling_next   = dwelling;
    tok_next           = '0;
    tok_next.valid     = fire;
    tok_next.kind      = dda_pkg::TOK_NONE;
    tok_next.tts       = dda_pkg::ACC_W'(item.tick_count) * dda_pkg::ACC_W'(SUBSTEPS);
    tok_next.restart   = scaled_ticks < (dda_pkg::TICK_W+dda_pkg::RF_W)'(last_len);
    tok_next.incr[0]   = item.incr_axis1;
    tok_next.incr[1]   = item.incr_axis2;
    tok_next.incr[2]   = item.incr_axis3;
    tok_next.incr[3]   = item.incr_axis4;
    tok_next.incr[4]   = item.incr_axis5;
    unique case (item.command)
      dda_pkg::CMD_TICK: begin
        if (ticks_left != '0) begin
          ticks_left_next = ticks_left - 1'b1;
          tok_next.done   = (ticks_left == dda_pkg::TICK_W'(1));
          tok_next.kind   = dwelling ? dda_pkg::TOK_NONE : dda_pkg::TOK_STEP;
        end
      end
      dda_pkg::CMD_LINE: begin
        ticks_left_next = item.tick_count;
        dwelling_next   = 1'b0;
        tok_next.kind   = dda_pkg::TOK_LOAD;
      end
      dda_pkg::CMD_DWELL: begin
        ticks_left_next = item.tick_count;
        dwelling_next   = 1'b1;
      end
      default: begin
      end
    endcase
    tok_next.busy = (ticks_left_next != '0);
  end

  // segment bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_left <= '0;
      last_len   <= '0;
      dwelling   <= 1'b0;
    end else if (fire) begin
      ticks_left <= ticks_left_next;
      dwelling   <= dwelling_next;
      if (item.command == dda_pkg::CMD_LINE) begin
        last_len <= item.tick_count;
      end
    end
  end

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      polarity_mask <= '0;
      reset_factor  <= dda_pkg::RF_W'(2);
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        dda_pkg::REG_POLARITY:     polarity_mask <= cfg.data[dda_pkg::AXES-1:0];
        dda_pkg::REG_RESET_FACTOR: reset_factor  <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  // token register at the head of the chain
  always_ff @(posedge clk) begin
    if (rst) begin
      tok.valid <= 1'b0;
    end else if (en) begin
      tok <= tok_next;
    end
  end

endmodule

// File: rtl/dda_cell.sv
module dda_cell #(
  parameter int IDX = 0
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          pol,
  input  dda_pkg::tok_t tok_in,
  output dda_pkg::tok_t tok_out
);

  logic [dda_pkg::ACC_W-1:0]  acc, acc_next;
  logic [dda_pkg::INCR_W-1:0] incr, incr_next;
  logic [dda_pkg::ACC_W-1:0]  delta, delta_next;
  logic                       run, run_next;
  logic                       dir, dir_next;
  logic                       step;
  logic [dda_pkg::INCR_W-1:0] raw, mag;
  logic                       neg;
  logic [dda_pkg::ACC_W-1:0]  sum, sum_sub;
  logic                       upd;
  dda_pkg::tok_t              tok_next;

  assign upd = en && tok_in.valid;
  assign raw = tok_in.incr[IDX];
  assign neg = raw[dda_pkg::INCR_W-1];
  assign mag = neg ? (dda_pkg::INCR_W'(0) - raw) : raw;

  // both outcomes of the phase add, picked by the sign of the plain sum and whether it is zero
  assign sum     = acc + dda_pkg::ACC_W'(incr);
  assign sum_sub = acc + delta;

  always_comb begin
    acc_next   = acc;
    incr_next  = incr;
    delta_next = delta;
    run_next   = run;
    dir_next   = dir;
    step       = 1'b0;
    case (tok_in.kind)
      dda_pkg::TOK_LOAD: begin
        incr_next  = mag;
        delta_next = dda_pkg::ACC_W'(mag) - tok_in.tts;
        run_next   = (mag != '0);
        if (mag != '0) begin
          dir_next = neg ^ pol;
        end
        if (tok_in.restart) begin
          acc_next = dda_pkg::ACC_W'(0) - dda_pkg::ACC_W'(mag);
        end
      end
      dda_pkg::TOK_STEP: begin
        if (run) begin
          if (sum != '0 && !sum[dda_pkg::ACC_W-1]) begin
            acc_next = sum_sub;
            step     = 1'b1;
          end else begin
            acc_next = sum;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // pass the token on with this axis filled in
  always_comb begin
    tok_next                = tok_in;
    tok_next.step_mask[IDX] = step;
    tok_next.dir_mask[IDX]  = dir_next;
  end

  // axis state
  always_ff @(posedge clk) begin
    if (rst) begin
      acc   <= '0;
      incr  <= '0;
      delta <= '0;
      run   <= 1'b0;
      dir   <= 1'b0;
    end else if (upd) begin
      acc   <= acc_next;
      incr  <= incr_next;
      delta <= delta_next;
      run   <= run_next;
      dir   <= dir_next;
    end
  end

  // token register toward the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else if (en) begin
      tok_out <= tok_next;
    end
  end

endmodule
